/* sv/lbcs_pkg.sv */
// Shared types and constants for the length bucket counting sort core.
`default_nettype none

package lbcs_pkg;

  // Field widths of the request and result channels.
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned LEN_W    = 31;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned BUCKET_W = 13;

  // Number of fraction bits kept after the leading one of a long length.
  localparam int unsigned FRAC_BITS = 5;

  // Function codes on the request channel.
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_COUNT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PLACE = 2'd2;

  // Operations that travel from the front end to the back end.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_COUNT = 2'd1,
    OP_PLACE = 2'd2
  } op_e;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COUNT,
    ST_PREFIX,
    ST_PLACE
  } back_state_e;

endpackage

`default_nettype wire

/* sv/length_bucket_counting_sort_core.sv */
// Top level of the length bucket counting sort core.
// Count and place requests each pass through the bucket sequencer as a memory read, then a write.
// A place result passes the classification register, the queue and the memory read into the result register.
// The first place request of a batch adds a prefix pass over the memory.
// A clear request sweeps zeros through all TOTAL buckets of the count memory (4704 at defaults).
// After reset the same sweep runs while in_ready_o stays low.
`default_nettype none

module length_bucket_counting_sort_core #(
  parameter int unsigned MAX_ITEMS     = 65536,
  parameter int unsigned EXACT_BUCKETS = 4096,
  parameter int unsigned LOG_BUCKETS   = 608
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [lbcs_pkg::FUNC_W-1:0]  func_i,
  input  wire logic [lbcs_pkg::LEN_W-1:0]   length_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [lbcs_pkg::POS_W-1:0]        position_o,
  output logic [lbcs_pkg::BUCKET_W-1:0]     bucket_o,
  output logic                              overflow_o
);

  localparam int unsigned EntW = $clog2(EXACT_BUCKETS + LOG_BUCKETS) + 2;

  logic            init_done;
  logic            q_in_valid, q_in_ready;
  logic [EntW-1:0] q_in_data;
  logic            q_out_valid, q_out_ready;
  logic [EntW-1:0] q_out_data;

  // Request classifier.
  lbcs_front #(
    .EXACT_BUCKETS (EXACT_BUCKETS),
    .LOG_BUCKETS   (LOG_BUCKETS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .enable_i     (init_done),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .length_i     (length_i),
    .push_valid_o (q_in_valid),
    .push_ready_i (q_in_ready),
    .push_data_o  (q_in_data)
  );

  // Decoupling queue.
  lbcs_fifo #(
    .WIDTH (EntW)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_in_valid),
    .push_ready_o (q_in_ready),
    .push_data_i  (q_in_data),
    .pop_valid_o  (q_out_valid),
    .pop_ready_i  (q_out_ready),
    .pop_data_o   (q_out_data)
  );

  // Bucket memory sequencer and result register.
  lbcs_back #(
    .MAX_ITEMS     (MAX_ITEMS),
    .EXACT_BUCKETS (EXACT_BUCKETS),
    .LOG_BUCKETS   (LOG_BUCKETS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_done_o (init_done),
    .pop_valid_i (q_out_valid),
    .pop_ready_o (q_out_ready),
    .pop_data_i  (q_out_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .position_o  (position_o),
    .bucket_o    (bucket_o),
    .overflow_o  (overflow_o)
  );

endmodule

`default_nettype wire

/* sv/lbcs_fifo.sv */
// Two-entry queue that decouples the classifier from the bucket sequencer.
`default_nettype none

module lbcs_fifo #(
  parameter int unsigned WIDTH = 15
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  logic [WIDTH-1:0] ent_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = ent_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* sv/lbcs_front.sv */
// Request front end: accepts requests and maps each length to its bucket.
`default_nettype none

module lbcs_front #(
  parameter int unsigned EXACT_BUCKETS = 4096,
  parameter int unsigned LOG_BUCKETS   = 608
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       enable_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [lbcs_pkg::FUNC_W-1:0] func_i,
  input  wire logic [lbcs_pkg::LEN_W-1:0]  length_i,
  output logic                            push_valid_o,
  input  wire logic                       push_ready_i,
  output logic [$clog2(EXACT_BUCKETS+LOG_BUCKETS)+1:0] push_data_o
);

  localparam int unsigned Total  = EXACT_BUCKETS + LOG_BUCKETS;
  localparam int unsigned BktW   = $clog2(Total);
  localparam int unsigned CalcW  = $clog2(EXACT_BUCKETS + 1024);
  localparam int unsigned Base   = $clog2(EXACT_BUCKETS + 1) - 1;
  localparam int unsigned LenW   = lbcs_pkg::LEN_W;
  localparam int unsigned FracW  = lbcs_pkg::FRAC_BITS;

  // Classification stage registers.
  logic                    a_valid_q, a_valid_d;
  lbcs_pkg::op_e           a_op_q, a_op_d;
  logic [LenW-1:0]         a_len_q;
  logic                    a_exact_q;
  logic [3:0]              a_any_q;
  logic [2:0]              a_pos_q [4];

  logic                    keep;
  logic                    accept;
  logic                    a_ready;
  logic [LenW:0]           len_pad;
  logic [3:0]              any_d;
  logic [2:0]              pos_d [4];

  logic [1:0]              grp;
  logic [4:0]              lead;
  logic [4:0]              shamt;
  logic [LenW-1:0]         shifted;
  logic [FracW-1:0]        frac;
  logic [4:0]              rel;
  logic [CalcW-1:0]        idx_calc;
  logic [CalcW-1:0]        idx_sat;
  logic [BktW-1:0]         idx;

  assign a_ready    = !a_valid_q || push_ready_i;
  assign in_ready_o = a_ready && enable_i;
  assign accept     = in_valid_i && in_ready_o;

  // Decode the function code; the unused code is dropped on acceptance.
  always_comb begin
    keep   = 1'b1;
    a_op_d = lbcs_pkg::OP_CLEAR;
    unique case (func_i)
      lbcs_pkg::FUNC_CLEAR: a_op_d = lbcs_pkg::OP_CLEAR;
      lbcs_pkg::FUNC_COUNT: a_op_d = lbcs_pkg::OP_COUNT;
      lbcs_pkg::FUNC_PLACE: a_op_d = lbcs_pkg::OP_PLACE;
      default:              keep   = 1'b0;
    endcase
  end

  // Leading-one search within each byte of the length.
  assign len_pad = {1'b0, length_i};
  always_comb begin
    for (int g = 0; g < 4; g++) begin
      any_d[g] = 1'b0;
      pos_d[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (len_pad[8*g+b]) begin
          any_d[g] = 1'b1;
          pos_d[g] = 3'(b);
        end
      end
    end
  end

  always_comb begin
    a_valid_d = a_valid_q;
    if (accept) begin
      a_valid_d = keep;
    end else if (push_ready_i) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_op_q    <= a_op_d;
      a_len_q   <= length_i;
      a_exact_q <= (length_i < LenW'(EXACT_BUCKETS));
      a_any_q   <= any_d;
      for (int g = 0; g < 4; g++) begin
        a_pos_q[g] <= pos_d[g];
      end
    end
  end

  // Pick the highest byte holding a one to form the leading-one position.
  always_comb begin
    grp = 2'd0;
    for (int g = 0; g < 4; g++) begin
      if (a_any_q[g]) begin
        grp = 2'(g);
      end
    end
    lead = {grp, a_pos_q[grp]};
  end

  // Log bucket: octave above the exact range, then the bits after the lead.
  always_comb begin
    shamt    = lead - 5'(FracW);
    shifted  = a_len_q >> shamt;
    frac     = shifted[FracW-1:0];
    rel      = lead - 5'(Base);
    idx_calc = CalcW'(EXACT_BUCKETS) + CalcW'({rel, {FracW{1'b0}}}) + CalcW'(frac);
    idx_sat  = (idx_calc > CalcW'(Total - 1)) ? CalcW'(Total - 1) : idx_calc;
    idx      = a_exact_q ? a_len_q[BktW-1:0] : idx_sat[BktW-1:0];
  end

  assign push_valid_o = a_valid_q;
  assign push_data_o  = {a_op_q, idx};

endmodule

`default_nettype wire

/* sv/lbcs_back.sv */
// Bucket sequencer: owns the count memory, runs clear, count, prefix and place.
`default_nettype none

module lbcs_back #(
  parameter int unsigned MAX_ITEMS     = 65536,
  parameter int unsigned EXACT_BUCKETS = 4096,
  parameter int unsigned LOG_BUCKETS   = 608
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  output logic                              init_done_o,
  input  wire logic                         pop_valid_i,
  output logic                              pop_ready_o,
  input  wire logic [$clog2(EXACT_BUCKETS+LOG_BUCKETS)+1:0] pop_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [lbcs_pkg::POS_W-1:0]        position_o,
  output logic [lbcs_pkg::BUCKET_W-1:0]     bucket_o,
  output logic                              overflow_o
);

  localparam int unsigned Total = EXACT_BUCKETS + LOG_BUCKETS;
  localparam int unsigned BktW  = $clog2(Total);
  localparam int unsigned PtrW  = $clog2(Total + 1);
  localparam int unsigned CntW  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned PosW  = lbcs_pkg::POS_W;
  localparam int unsigned BOutW = lbcs_pkg::BUCKET_W;

  // Bucket count memory with registered read data.
  logic [CntW-1:0] mem [Total];
  logic [CntW-1:0] rd_q;
  logic            rd_en;
  logic [BktW-1:0] rd_addr;
  logic            wr_en;
  logic [BktW-1:0] wr_addr;
  logic [CntW-1:0] wr_data;

  lbcs_pkg::back_state_e state_q, state_d;
  logic [PtrW-1:0] ptr_q, ptr_d;
  logic [BktW-1:0] pwa_q, pwa_d;
  logic            pend_q, pend_d;
  logic [CntW-1:0] sum_q, sum_d;
  logic [CntW-1:0] items_q, items_d;
  logic            prefix_q, prefix_d;
  logic            cap_q, cap_d;
  logic            init_q, init_d;
  logic [BktW-1:0] cur_q, cur_d;

  logic                 out_valid_q, out_valid_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [BOutW-1:0]     bkt_q, bkt_d;
  logic                 ovf_q, ovf_d;
  logic                 load;

  lbcs_pkg::op_e        op;
  logic [BktW-1:0]      op_idx;
  logic                 slot_free;
  logic                 slot_ovf;
  logic [CntW+PosW-1:0] pos_ext;
  logic [BktW+BOutW-1:0] bkt_ext;

  assign op        = lbcs_pkg::op_e'(pop_data_i[BktW+1:BktW]);
  assign op_idx    = pop_data_i[BktW-1:0];
  assign slot_free = !out_valid_q || out_ready_i;
  assign slot_ovf  = (rd_q >= CntW'(MAX_ITEMS));
  assign pos_ext   = {{PosW{1'b0}}, rd_q};
  assign bkt_ext   = {{BOutW{1'b0}}, cur_q};

  // Sequencer next state and memory control.
  always_comb begin
    state_d  = state_q;
    ptr_d    = ptr_q;
    pwa_d    = pwa_q;
    pend_d   = 1'b0;
    sum_d    = sum_q;
    items_d  = items_q;
    prefix_d = prefix_q;
    cap_d    = cap_q;
    init_d   = init_q;
    cur_d    = cur_q;
    rd_en    = 1'b0;
    rd_addr  = cur_q;
    wr_en    = 1'b0;
    wr_addr  = cur_q;
    wr_data  = rd_q + CntW'(1);
    pop_ready_o = 1'b0;
    load     = 1'b0;
    pos_d    = pos_q;
    bkt_d    = bkt_q;
    ovf_d    = ovf_q;

    unique case (state_q)
      // Sweep zeros through every bucket, one per cycle.
      lbcs_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = ptr_q[BktW-1:0];
        wr_data = '0;
        ptr_d   = ptr_q + PtrW'(1);
        if (ptr_q == PtrW'(Total - 1)) begin
          init_d  = 1'b1;
          state_d = lbcs_pkg::ST_IDLE;
        end
      end

      // Take the next request from the queue.
      lbcs_pkg::ST_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          cur_d = op_idx;
          unique case (op)
            lbcs_pkg::OP_CLEAR: begin
              items_d  = '0;
              prefix_d = 1'b0;
              cap_d    = 1'b0;
              ptr_d    = '0;
              state_d  = lbcs_pkg::ST_CLEAR;
            end
            lbcs_pkg::OP_COUNT: begin
              if (!prefix_q) begin
                if (items_q >= CntW'(MAX_ITEMS)) begin
                  cap_d = 1'b1;
                end else begin
                  rd_en   = 1'b1;
                  rd_addr = op_idx;
                  state_d = lbcs_pkg::ST_COUNT;
                end
              end
            end
            lbcs_pkg::OP_PLACE: begin
              if (prefix_q) begin
                rd_en   = 1'b1;
                rd_addr = op_idx;
                state_d = lbcs_pkg::ST_PLACE;
              end else begin
                ptr_d   = '0;
                sum_d   = '0;
                state_d = lbcs_pkg::ST_PREFIX;
              end
            end
            default: ;
          endcase
        end
      end

      // Write back the incremented count.
      lbcs_pkg::ST_COUNT: begin
        wr_en   = 1'b1;
        items_d = items_q + CntW'(1);
        state_d = lbcs_pkg::ST_IDLE;
      end

      // Exclusive prefix sum: read one bucket, write the previous one.
      lbcs_pkg::ST_PREFIX: begin
        if (pend_q) begin
          wr_en   = 1'b1;
          wr_addr = pwa_q;
          wr_data = sum_q;
          sum_d   = CntW'(sum_q + rd_q);
        end
        if (ptr_q != PtrW'(Total)) begin
          rd_en   = 1'b1;
          rd_addr = ptr_q[BktW-1:0];
          pwa_d   = ptr_q[BktW-1:0];
          pend_d  = 1'b1;
          ptr_d   = ptr_q + PtrW'(1);
        end else if (!pend_q) begin
          prefix_d = 1'b1;
          rd_en    = 1'b1;
          rd_addr  = cur_q;
          state_d  = lbcs_pkg::ST_PLACE;
        end
      end

      // Hand out the slot and advance the bucket once the result slot is free.
      lbcs_pkg::ST_PLACE: begin
        if (slot_free) begin
          load    = 1'b1;
          ovf_d   = cap_q || slot_ovf;
          pos_d   = (cap_q || slot_ovf) ? '0 : pos_ext[PosW-1:0];
          bkt_d   = bkt_ext[BOutW-1:0];
          wr_en   = !slot_ovf;
          state_d = lbcs_pkg::ST_IDLE;
        end
      end

      default: state_d = lbcs_pkg::ST_IDLE;
    endcase
  end

  // Result register in front of the output channel.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lbcs_pkg::ST_CLEAR;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      items_q     <= '0;
      prefix_q    <= 1'b0;
      cap_q       <= 1'b0;
      init_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      items_q     <= items_d;
      prefix_q    <= prefix_d;
      cap_q       <= cap_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk_i) begin
    pwa_q <= pwa_d;
    sum_q <= sum_d;
    cur_q <= cur_d;
    pos_q <= pos_d;
    bkt_q <= bkt_d;
    ovf_q <= ovf_d;
  end

  // Count memory ports.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign init_done_o = init_q;
  assign out_valid_o = out_valid_q;
  assign position_o  = pos_q;
  assign bucket_o    = bkt_q;
  assign overflow_o  = ovf_q;

`ifndef ASSERT_OFF
  // Counting never happens once the prefix sums exist.
  a_count_before_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lbcs_pkg::ST_COUNT) |-> !prefix_q)
    else $error("count update after prefix pass");

  // The item counter never passes capacity.
  a_items_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    items_q <= CntW'(MAX_ITEMS))
    else $error("item counter beyond capacity");

  // An overflowed result carries a zero position.
  a_ovf_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ovf_q) |-> (pos_q == '0))
    else $error("overflow result with nonzero position");

  // The initial clearing pass completes once and never repeats its gate.
  a_init_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(init_q))
    else $error("init done dropped");

  // Placed buckets always lie inside the table.
  a_bucket_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lbcs_pkg::ST_PLACE) |-> (cur_q <= BktW'(Total - 1)))
    else $error("bucket index past table");
`endif

endmodule

`default_nettype wire
